// ===== hdl/fls_pkg.sv =====
// ----------------------------------------------------------------------------
// fls_pkg: shared constants and types for the saturating low-pass FIR
// Widths, tap count, Q1.23 design coefficients and the rounding helper that
// turns them into the working coefficient format.
// ----------------------------------------------------------------------------
package fls_pkg;

  localparam int TAPS        = 21;
  localparam int COEFF_BITS  = 16;
  localparam int DESIGN_TAPS = 21;
  localparam int SAMPLE_W    = 32;
  localparam int FILT_W      = 16;
  localparam int FRAC_BITS   = COEFF_BITS - 1;
  localparam int PROD_W      = SAMPLE_W + COEFF_BITS;
  localparam int ACC_W       = PROD_W + $clog2(TAPS);

  typedef logic signed [SAMPLE_W-1:0]   sample_t;
  typedef logic signed [COEFF_BITS-1:0] coeff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [FILT_W-1:0]     filt_t;

  localparam filt_t FILT_MAX = filt_t'(16'sh7FFF);
  localparam filt_t FILT_MIN = filt_t'(16'sh8000);

  localparam acc_t ACC_HI  = acc_t'(longint'(32767) <<< FRAC_BITS);
  localparam acc_t ACC_LO  = acc_t'(-(longint'(32768) <<< FRAC_BITS));
  localparam acc_t ACC_RND = acc_t'((longint'(1) <<< FRAC_BITS) - 1);

  // Symmetric low-pass design, Q1.23, rounded to nearest
  localparam logic signed [24:0] DESIGN_Q23 [DESIGN_TAPS] = '{
    -25'sd168646,  -25'sd490129,  -25'sd513202,  -25'sd91766,
     25'sd429924,   25'sd278677,  -25'sd474399,  -25'sd718526,
     25'sd531667,   25'sd2607636,  25'sd3644271,  25'sd2607636,
     25'sd531667,  -25'sd718526,  -25'sd474399,   25'sd278677,
     25'sd429924,  -25'sd91766,   -25'sd513202,  -25'sd490129,
    -25'sd168646
  };

  // Round Q1.23 to Q1.(COEFF_BITS-1), ties toward plus infinity
  function automatic coeff_t coeff_at(input int idx);
    longint v;
    int     sh;
    sh = 24 - COEFF_BITS;
    if (idx < 0 || idx >= DESIGN_TAPS) begin
      return '0;
    end
    v = longint'(DESIGN_Q23[idx]);
    if (sh > 0) begin
      v = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    end
    return coeff_t'(v);
  endfunction

endpackage

// ===== hdl/fls_if.sv =====
// ----------------------------------------------------------------------------
// fls_in_if / fls_out_if: valid-ready channels of the FIR
// Sample channel into the filter and result channel out of it.
// ----------------------------------------------------------------------------
interface fls_in_if import fls_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    start_block;

  modport source (output valid, output sample, output start_block, input ready);
  modport sink   (input valid, input sample, input start_block, output ready);
endinterface

interface fls_out_if import fls_pkg::*; ();
  logic  valid;
  logic  ready;
  filt_t filtered;
  logic  clipped;

  modport source (output valid, output filtered, output clipped, input ready);
  modport sink   (input valid, input filtered, input clipped, output ready);
endinterface

// ===== hdl/fls_cell.sv =====
// ----------------------------------------------------------------------------
// fls_cell: one tap of the transposed FIR chain
// Multiplies the broadcast sample by its coefficient and adds the partial sum
// handed over by the next cell; the result is held for the previous cell.
// ----------------------------------------------------------------------------
module fls_cell import fls_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    clr,
  input  sample_t x,
  input  coeff_t  coeff,
  input  acc_t    sum_in,
  output acc_t    sum_out
);

  prod_t prod;
  acc_t  sum_r;
  acc_t  sum_nxt;

  assign prod    = x * coeff;
  // clr drops all older contributions: history starts from zero
  assign sum_nxt = acc_t'(prod) + (clr ? acc_t'('0) : sum_in);
  assign sum_out = sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (en) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

// ===== hdl/fls_sat.sv =====
// ----------------------------------------------------------------------------
// fls_sat: truncate and saturate stage with output register
// Scales the full-precision sum back to integer (toward zero), clamps it to
// 16 bits, flags clipping and holds the result for the output transfer.
// ----------------------------------------------------------------------------
module fls_sat import fls_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  acc_valid,
  output logic  acc_ready,
  input  acc_t  acc,
  fls_out_if.source out_ch
);

  acc_t  scaled;
  filt_t filt_nxt;
  logic  clip_nxt;
  logic  load;

  assign acc_ready = !out_ch.valid || out_ch.ready;
  assign load      = acc_valid && acc_ready;
  assign scaled    = acc[ACC_W-1] ? ((acc + ACC_RND) >>> FRAC_BITS) : (acc >>> FRAC_BITS);

  always_comb begin
    priority if (acc > ACC_HI) begin
      filt_nxt = FILT_MAX;
      clip_nxt = 1'b1;
    end else if (acc < ACC_LO) begin
      filt_nxt = FILT_MIN;
      clip_nxt = 1'b1;
    end else begin
      filt_nxt = scaled[FILT_W-1:0];
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ch.valid <= 1'b0;
    end else if (load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.filtered <= filt_nxt;
      out_ch.clipped  <= clip_nxt;
    end
  end

  a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.clipped |->
      (out_ch.filtered == FILT_MAX || out_ch.filtered == FILT_MIN))
    else $error("clipped result not at a rail");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

  a_acc_held: assert property (@(posedge clk) disable iff (!rst_n)
    acc_valid && !acc_ready |=> acc_valid && $stable(acc))
    else $error("pending sum changed while stalled");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_ch.valid)
    else $error("loaded result not presented");

endmodule

// ===== hdl/fir_lowpass_saturating.sv =====
// ----------------------------------------------------------------------------
// fir_lowpass_saturating: 21-tap low-pass FIR with 16-bit saturation
// Transposed chain of tap cells, one full-precision sum per sample, then a
// truncate-and-clamp output stage.
// ----------------------------------------------------------------------------
// Takes one 32-bit signed sample per clock unless the output stalls, and
// returns one 16-bit result per sample, in order. A result passes the
// tap-cell register, then the output register; throughput is one sample per
// cycle unless stalled, set by the single multiply-add in each tap cell. A
// sample with start_block set is filtered as if all earlier samples were
// zero. clipped marks results whose exact sum lay outside the 16-bit range.
module fir_lowpass_saturating import fls_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  fls_in_if.sink    in_ch,
  fls_out_if.source out_ch
);

  acc_t sums [TAPS+1];
  logic acc_valid_r;
  logic acc_valid_nxt;
  logic acc_ready;
  logic in_fire;

  assign in_ch.ready = !acc_valid_r || acc_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign sums[TAPS]  = '0;

  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    fls_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (in_fire),
      .clr     (in_ch.start_block),
      .x       (in_ch.sample),
      .coeff   (coeff_at(k)),
      .sum_in  (sums[k+1]),
      .sum_out (sums[k])
    );
  end

  always_comb begin
    acc_valid_nxt = acc_valid_r;
    if (in_fire) begin
      acc_valid_nxt = 1'b1;
    end else if (acc_ready) begin
      acc_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_valid_r <= 1'b0;
    end else begin
      acc_valid_r <= acc_valid_nxt;
    end
  end

  fls_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_valid (acc_valid_r),
    .acc_ready (acc_ready),
    .acc       (sums[0]),
    .out_ch    (out_ch)
  );

endmodule
